>>> hdl/multi_stack_shared_pool_assert.svh
// ----------------------------------------------------------------------------
// multi_stack_shared_pool assertion macros
// clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef MULTI_STACK_SHARED_POOL_ASSERT_SVH
`define MULTI_STACK_SHARED_POOL_ASSERT_SVH

// same-cycle implication
`define MSSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mssp_pkg.sv
// ----------------------------------------------------------------------------
// mssp_pkg
// shared constants and types of the multi-stack shared pool
// ----------------------------------------------------------------------------
package mssp_pkg;

  localparam int NUM_STACKS  = 4;
  localparam int POOL_DEPTH  = 64;
  localparam int DATA_W      = 32;
  localparam int STACK_ID_W  = 2;
  localparam int STACK_SLOTS = (NUM_STACKS < (1 << STACK_ID_W)) ? NUM_STACKS
                                                               : (1 << STACK_ID_W);
  localparam int IDX_W       = $clog2(POOL_DEPTH);
  localparam int LINK_W      = $clog2(POOL_DEPTH + 1);

  localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_DEPTH);

  localparam logic       FUNC_PUSH = 1'b0;
  localparam logic       FUNC_POP  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DATA_W-1:0] data_t;

  // request from the sequencer to the two pool memories
  typedef struct packed {
    logic  re;
    idx_t  raddr;
    logic  link_we;
    logic  data_we;
    idx_t  waddr;
    link_t link_wdata;
    data_t data_wdata;
  } mem_req_t;

endpackage

>>> hdl/mssp_ram.sv
// ----------------------------------------------------------------------------
// mssp_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mssp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/mssp_ctrl.sv
// ----------------------------------------------------------------------------
// mssp_ctrl
// two-step sequencer: stack tops, free-list head, link valid bits, result reg
// ----------------------------------------------------------------------------
module mssp_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic                              func,
  input  logic [mssp_pkg::STACK_ID_W-1:0]   stack_id,
  input  logic [mssp_pkg::DATA_W-1:0]       push_value,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [1:0]                        status,
  output logic [mssp_pkg::DATA_W-1:0]       pop_value,
  output mssp_pkg::mem_req_t                mem,
  input  mssp_pkg::link_t                   link_rdata,
  input  mssp_pkg::data_t                   data_rdata
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                              state;
  logic                              op_func;
  logic [mssp_pkg::STACK_ID_W-1:0]   op_sid;
  logic [mssp_pkg::DATA_W-1:0]       op_val;
  mssp_pkg::idx_t                    op_idx;
  logic                              op_ok;
  logic                              vld_q;
  mssp_pkg::link_t                   free_head;
  mssp_pkg::link_t                   stack_top [mssp_pkg::STACK_SLOTS];
  logic [mssp_pkg::POOL_DEPTH-1:0]   link_vld;

  logic                              accept;
  logic                              sid_ok;
  mssp_pkg::link_t                   top_rd;
  mssp_pkg::link_t                   cand;
  logic                              cand_ok;
  mssp_pkg::idx_t                    cand_idx;
  logic                              done;
  mssp_pkg::link_t                   link_rd;
  mssp_pkg::link_t                   link_nxt;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign sid_ok    = (32'(stack_id) < mssp_pkg::NUM_STACKS);
  assign top_rd    = sid_ok ? stack_top[stack_id] : mssp_pkg::NIL;
  assign cand      = (func == mssp_pkg::FUNC_PUSH) ? free_head : top_rd;
  assign cand_ok   = sid_ok && (cand < mssp_pkg::NIL);
  assign cand_idx  = cand[mssp_pkg::IDX_W-1:0];
  assign done      = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  // unwritten links keep their reset chain
  assign link_rd  = vld_q ? link_rdata
                          : mssp_pkg::LINK_W'(op_idx) + mssp_pkg::LINK_W'(1);
  assign link_nxt = (link_rd < mssp_pkg::NIL) ? link_rd : mssp_pkg::NIL;

  always_comb begin
    mem            = '0;
    mem.re         = accept && cand_ok;
    mem.raddr      = cand_idx;
    mem.waddr      = op_idx;
    mem.data_wdata = op_val;
    if (op_func == mssp_pkg::FUNC_PUSH) begin
      mem.link_wdata = stack_top[op_sid];
    end else begin
      mem.link_wdata = free_head;
    end
    mem.link_we    = done && op_ok;
    mem.data_we    = done && op_ok && (op_func == mssp_pkg::FUNC_PUSH);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_func <= func;
      op_sid  <= stack_id;
      op_val  <= push_value;
      op_idx  <= cand_idx;
      op_ok   <= cand_ok;
      vld_q   <= link_vld[cand_idx];
    end
    if (done) begin
      if (op_ok) begin
        status    <= mssp_pkg::ST_OK;
        pop_value <= (op_func == mssp_pkg::FUNC_POP) ? data_rdata : '0;
      end else begin
        status    <= (op_func == mssp_pkg::FUNC_POP) ? mssp_pkg::ST_UNDERFLOW
                                                     : mssp_pkg::ST_OVERFLOW;
        pop_value <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      free_head <= '0;
      link_vld  <= '0;
      for (int i = 0; i < mssp_pkg::STACK_SLOTS; i++) begin
        stack_top[i] <= mssp_pkg::NIL;
      end
    end else begin
      if (accept) begin
        state <= S_EXEC;
      end else if (done) begin
        state <= S_IDLE;
      end
      if (done) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (done && op_ok) begin
        link_vld[op_idx] <= 1'b1;
        if (op_func == mssp_pkg::FUNC_PUSH) begin
          free_head         <= link_nxt;
          stack_top[op_sid] <= mssp_pkg::LINK_W'(op_idx);
        end else begin
          free_head         <= mssp_pkg::LINK_W'(op_idx);
          stack_top[op_sid] <= link_nxt;
        end
      end
    end
  end

`include "multi_stack_shared_pool_assert.svh"

  `MSSP_ASSERT_NEXT(a_accept_exec, req_valid && !req_stall, state == S_EXEC, "accept did not start exec")
  `MSSP_ASSERT_SAME(a_no_rw_overlap, mem.re, !mem.link_we && !mem.data_we, "pool read and write overlap")
  `MSSP_ASSERT_NEXT(a_exec_result, done, rsp_valid && state == S_IDLE, "exec did not load result")
  `MSSP_ASSERT_SAME(a_err_zero, rsp_valid && status != mssp_pkg::ST_OK, pop_value == '0, "error word with nonzero value")

endmodule

>>> hdl/multi_stack_shared_pool.sv
// ----------------------------------------------------------------------------
// multi_stack_shared_pool
// several lifo stacks sharing one linked pool of entries with a free list
//
//   channel  valid      stall      fields
//   request  req_valid  req_stall  func, stack_id, push_value
//   response rsp_valid  rsp_stall  status, pop_value
//
// each word takes an accept step, which reads the link and data memories,
// and an exec step, which writes them back and loads the result register
// a held result stalls only the exec step; no new word is taken meanwhile
// synchronous reset, no clearing pass: link valid bits restore the reset chain
// ----------------------------------------------------------------------------
module multi_stack_shared_pool (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic                              func,
  input  logic [mssp_pkg::STACK_ID_W-1:0]   stack_id,
  input  logic signed [mssp_pkg::DATA_W-1:0] push_value,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [1:0]                        status,
  output logic signed [mssp_pkg::DATA_W-1:0] pop_value
);

  mssp_pkg::mem_req_t mem;
  mssp_pkg::link_t    link_rdata;
  mssp_pkg::data_t    data_rdata;
  mssp_pkg::data_t    pop_raw;

  mssp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .func       (func),
    .stack_id   (stack_id),
    .push_value (push_value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .pop_value  (pop_raw),
    .mem        (mem),
    .link_rdata (link_rdata),
    .data_rdata (data_rdata)
  );

  assign pop_value = pop_raw;

  mssp_ram #(
    .WIDTH (mssp_pkg::LINK_W),
    .DEPTH (mssp_pkg::POOL_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem.link_we),
    .waddr (mem.waddr),
    .wdata (mem.link_wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (link_rdata)
  );

  mssp_ram #(
    .WIDTH (mssp_pkg::DATA_W),
    .DEPTH (mssp_pkg::POOL_DEPTH)
  ) u_data_ram (
    .clk   (clk),
    .we    (mem.data_we),
    .waddr (mem.waddr),
    .wdata (mem.data_wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (data_rdata)
  );

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for multi_stack_shared_pool
// drives push and pop words through a table of directed cases and then through
// random runs biased towards filling or draining the pool, keeps a private copy
// of the stacks and the free list to predict responses (typed table rows give
// their own), and compares status and popped word with each response in order,
// under several idling patterns and one long response hold-off
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_WORDS  = 175;
  localparam int NUM_PHASES   = 8;
  localparam int NUM_ROWS     = 22;

  localparam logic       FUNC_PUSH    = mssp_pkg::FUNC_PUSH;
  localparam logic       FUNC_POP     = mssp_pkg::FUNC_POP;
  localparam logic [1:0] ST_OK        = mssp_pkg::ST_OK;
  localparam logic [1:0] ST_OVERFLOW  = mssp_pkg::ST_OVERFLOW;
  localparam logic [1:0] ST_UNDERFLOW = mssp_pkg::ST_UNDERFLOW;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] word;
  } pool_result_t;

  typedef struct packed {
    logic        op;
    logic [1:0]  sid;
    logic [31:0] value;
    logic [6:0]  reps;
    bit          typed;
    logic [1:0]  st;
    logic [31:0] word;
  } stim_row_t;

  logic                                  clk;
  logic                                  rst;
  logic                                  req_valid;
  logic                                  req_stall;
  logic                                  func;
  logic [mssp_pkg::STACK_ID_W-1:0]       stack_id;
  logic signed [mssp_pkg::DATA_W-1:0]    push_value;
  logic                                  rsp_valid;
  logic                                  rsp_stall;
  logic [1:0]                            status;
  logic signed [mssp_pkg::DATA_W-1:0]    pop_value;

  // private copy of the pool
  logic [31:0]      pool_word [mssp_pkg::POOL_DEPTH];
  mssp_pkg::link_t  pool_next [mssp_pkg::POOL_DEPTH];
  mssp_pkg::link_t  stack_head [mssp_pkg::NUM_STACKS];
  mssp_pkg::link_t  free_ptr;

  pool_result_t  pending_results [$];
  pool_result_t  cur_want;
  bit            cur_typed;
  idle_mode_t    idle_mode;
  int            hold_ticket;
  int            fail_count;
  int            cycle_count;

  idle_mode_t phase_modes [NUM_PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                                           IDLE_NONE, IDLE_BOTH, IDLE_SENDER, IDLE_RECEIVER};
  logic [31:0] extreme_words [4] = '{32'h0000_0000, 32'hffff_ffff,
                                     32'h7fff_ffff, 32'h8000_0000};
  stim_row_t directed_rows [NUM_ROWS];

  multi_stack_shared_pool dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .func       (func),
    .stack_id   (stack_id),
    .push_value (push_value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .pop_value  (pop_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int idle_pct(idle_mode_t m, bit receiver);
    case (m)
      IDLE_SENDER:   return receiver ? 0 : 88;
      IDLE_RECEIVER: return receiver ? 88 : 0;
      IDLE_BOTH:     return 26;
      default:       return 0;
    endcase
  endfunction

  function automatic void pool_step(input logic op, input logic [1:0] sid,
                                    input logic [31:0] value, output pool_result_t res);
    mssp_pkg::link_t slot;
    res.word = '0;
    if (op == FUNC_PUSH) begin
      slot = free_ptr;
      if (sid >= mssp_pkg::NUM_STACKS || slot >= mssp_pkg::POOL_DEPTH) begin
        res.status = ST_OVERFLOW;
      end else begin
        free_ptr = (pool_next[slot] < mssp_pkg::POOL_DEPTH) ? pool_next[slot]
                                                             : mssp_pkg::NIL;
        pool_word[slot] = value;
        pool_next[slot] = stack_head[sid];
        stack_head[sid] = slot;
        res.status = ST_OK;
      end
    end else begin
      if (sid >= mssp_pkg::NUM_STACKS || stack_head[sid] >= mssp_pkg::POOL_DEPTH) begin
        res.status = ST_UNDERFLOW;
      end else begin
        slot = stack_head[sid];
        stack_head[sid] = (pool_next[slot] < mssp_pkg::POOL_DEPTH) ? pool_next[slot]
                                                                    : mssp_pkg::NIL;
        pool_next[slot] = free_ptr;
        free_ptr = slot;
        res.word = pool_word[slot];
        res.status = ST_OK;
      end
    end
  endfunction

  task automatic send_word(input logic op, input logic [1:0] sid, input logic [31:0] value,
                           input bit typed, input pool_result_t want);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct(idle_mode, 1'b0)) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid  <= 1'b1;
    func       <= op;
    stack_id   <= sid;
    push_value <= value;
    cur_typed  = typed;
    cur_want   = want;
    do @(posedge clk); while (req_stall);
  endtask

  // response side, with the long hold-off counted here
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_ticket) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < idle_pct(idle_mode, 1'b1));
      end
    end
  end

  always @(posedge clk) begin
    pool_result_t predicted;
    pool_result_t oldest;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        pool_step(func, stack_id, push_value, predicted);
        pending_results.push_back(cur_typed ? cur_want : predicted);
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t expected no word, got status %0d value %h",
                   $time, status, pop_value);
        end else begin
          oldest = pending_results.pop_front();
          if (status !== oldest.status) begin
            fail_count++;
            $display("%0t status expected %0d got %0d", $time, oldest.status, status);
          end
          if (pop_value !== oldest.word) begin
            fail_count++;
            $display("%0t pop_value expected %h got %h", $time, oldest.word, pop_value);
          end
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[multi_stack_shared_pool] ERROR");
    $finish;
  end

  initial begin
    logic        op;
    logic [1:0]  sid;
    logic [31:0] value;
    int          run_left;
    int          push_pct;
    pool_result_t want;

    rst         = 1'b1;
    req_valid   = 1'b0;
    func        = FUNC_PUSH;
    stack_id    = '0;
    push_value  = '0;
    cur_typed   = 1'b0;
    cur_want    = '0;
    idle_mode   = IDLE_NONE;
    hold_ticket = 0;
    fail_count  = 0;
    run_left    = 0;
    push_pct    = 50;

    for (int i = 0; i < mssp_pkg::POOL_DEPTH; i++) begin
      pool_word[i] = '0;
      pool_next[i] = (i == mssp_pkg::POOL_DEPTH - 1) ? mssp_pkg::NIL
                                                      : mssp_pkg::link_t'(i + 1);
    end
    for (int s = 0; s < mssp_pkg::NUM_STACKS; s++) stack_head[s] = mssp_pkg::NIL;
    free_ptr = '0;

    directed_rows = '{
      '{FUNC_POP,  2'd0, 32'h0000_0000, 7'd1,  1'b1, ST_UNDERFLOW, 32'h0000_0000},
      '{FUNC_POP,  2'd3, 32'h1234_5678, 7'd1,  1'b1, ST_UNDERFLOW, 32'h0000_0000},
      '{FUNC_PUSH, 2'd0, 32'h7fff_ffff, 7'd1,  1'b1, ST_OK,        32'h0000_0000},
      '{FUNC_PUSH, 2'd1, 32'h8000_0000, 7'd1,  1'b1, ST_OK,        32'h0000_0000},
      '{FUNC_PUSH, 2'd2, 32'h0000_0000, 7'd1,  1'b1, ST_OK,        32'h0000_0000},
      '{FUNC_PUSH, 2'd3, 32'hffff_ffff, 7'd1,  1'b1, ST_OK,        32'h0000_0000},
      '{FUNC_POP,  2'd0, 32'hffff_ffff, 7'd1,  1'b1, ST_OK,        32'h7fff_ffff},
      '{FUNC_POP,  2'd1, 32'h0000_0000, 7'd1,  1'b1, ST_OK,        32'h8000_0000},
      '{FUNC_POP,  2'd2, 32'h0000_0000, 7'd1,  1'b1, ST_OK,        32'h0000_0000},
      '{FUNC_POP,  2'd3, 32'h0000_0000, 7'd1,  1'b1, ST_OK,        32'hffff_ffff},
      '{FUNC_POP,  2'd3, 32'h0000_0000, 7'd1,  1'b1, ST_UNDERFLOW, 32'h0000_0000},
      '{FUNC_PUSH, 2'd2, 32'ha5a5_0000, 7'd64, 1'b0, ST_OK,        32'h0000_0000},
      '{FUNC_PUSH, 2'd1, 32'h5555_5555, 7'd1,  1'b1, ST_OVERFLOW,  32'h0000_0000},
      '{FUNC_POP,  2'd2, 32'h0000_0000, 7'd3,  1'b0, ST_OK,        32'h0000_0000},
      '{FUNC_PUSH, 2'd0, 32'hc0de_0000, 7'd3,  1'b0, ST_OK,        32'h0000_0000},
      '{FUNC_PUSH, 2'd3, 32'hffff_ffff, 7'd1,  1'b1, ST_OVERFLOW,  32'h0000_0000},
      '{FUNC_POP,  2'd0, 32'h0000_0000, 7'd3,  1'b0, ST_OK,        32'h0000_0000},
      '{FUNC_POP,  2'd0, 32'h0000_0000, 7'd1,  1'b1, ST_UNDERFLOW, 32'h0000_0000},
      '{FUNC_POP,  2'd2, 32'h0000_0000, 7'd61, 1'b0, ST_OK,        32'h0000_0000},
      '{FUNC_POP,  2'd2, 32'h0000_0000, 7'd1,  1'b1, ST_UNDERFLOW, 32'h0000_0000},
      '{FUNC_PUSH, 2'd1, 32'h0000_0000, 7'd1,  1'b1, ST_OK,        32'h0000_0000},
      '{FUNC_POP,  2'd1, 32'h0000_0000, 7'd1,  1'b1, ST_OK,        32'h0000_0000}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        want.status = directed_rows[r].st;
        want.word   = directed_rows[r].word;
        send_word(directed_rows[r].op, directed_rows[r].sid, directed_rows[r].value + k,
                  directed_rows[r].typed, want);
      end
    end

    // random runs that lean towards filling, draining or neither
    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_mode = phase_modes[p];
      if (p == 0) hold_ticket++;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (run_left == 0) begin
          run_left = $urandom_range(90, 10);
          case ($urandom_range(2))
            0:       push_pct = 80;
            1:       push_pct = 20;
            default: push_pct = 50;
          endcase
        end
        run_left--;
        op    = ($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_POP;
        sid   = 2'($urandom_range((1 << mssp_pkg::STACK_ID_W) - 1));
        value = ($urandom_range(7) == 0) ? extreme_words[$urandom_range(3)] : $urandom;
        send_word(op, sid, value, 1'b0, '0);
      end
    end
    @(negedge clk);
    req_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("[multi_stack_shared_pool] OK");
    else
      $display("[multi_stack_shared_pool] ERROR");
    $finish;
  end

endmodule
